// ----- src/sgi_pkg.sv -----
package sgi_pkg;

    // Field and datapath widths
    localparam int COORD_WIDTH       = 16;
    localparam int CUT_FRACTION_BITS = 16;
    localparam int DIFF_W            = COORD_WIDTH + 1;
    localparam int PROD_W            = 2 * DIFF_W;
    localparam int SUM_W             = PROD_W + 1;
    localparam int CUT_W             = CUT_FRACTION_BITS + 1;
    localparam int THRESH_W          = 34;

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 64;
    localparam logic REG_THRESH = 1'b0;
    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(1);

    // Beat that travels down the divider chain
    typedef struct packed {
        logic                         ok;
        logic                         eq;
        logic [SUM_W-1:0]             dmag;
        logic [SUM_W-1:0]             rem;
        logic [CUT_FRACTION_BITS-1:0] quo;
    } sgi_div_t;

endpackage

// ----- src/sgi_channels.sv -----
interface sgi_seg_if;
    import sgi_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] a_start_x;
    logic signed [COORD_WIDTH-1:0] a_start_y;
    logic signed [COORD_WIDTH-1:0] a_end_x;
    logic signed [COORD_WIDTH-1:0] a_end_y;
    logic signed [COORD_WIDTH-1:0] b_start_x;
    logic signed [COORD_WIDTH-1:0] b_start_y;
    logic signed [COORD_WIDTH-1:0] b_end_x;
    logic signed [COORD_WIDTH-1:0] b_end_y;

    modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                    b_start_x, b_start_y, b_end_x, b_end_y, input ready);
    modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                  b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface sgi_res_if;
    import sgi_pkg::*;
    logic             valid;
    logic             ready;
    logic             hit;
    logic [CUT_W-1:0] cut;

    modport source (output valid, hit, cut, input ready);
    modport sink (input valid, hit, cut, output ready);
endinterface

// ----- src/sgi_front.sv -----
module sgi_front
    import sgi_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          enable,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] x1,
    input  logic signed [COORD_WIDTH-1:0] y1,
    input  logic signed [COORD_WIDTH-1:0] x2,
    input  logic signed [COORD_WIDTH-1:0] y2,
    input  logic signed [COORD_WIDTH-1:0] x3,
    input  logic signed [COORD_WIDTH-1:0] y3,
    input  logic signed [COORD_WIDTH-1:0] x4,
    input  logic signed [COORD_WIDTH-1:0] y4,
    input  logic [THRESH_W-1:0]           thresh,
    output logic                          out_valid,
    output sgi_div_t                      out_beat
);

    // num/den in 0..1, den nonzero
    function automatic logic in_unit(input logic signed [SUM_W-1:0] num,
                                     input logic signed [SUM_W-1:0] den);
        logic [SUM_W-1:0] nm;
        logic [SUM_W-1:0] dm;
        nm = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
        dm = den[SUM_W-1] ? SUM_W'(-den) : SUM_W'(den);
        if (num == '0)
            in_unit = 1'b1;
        else if (num[SUM_W-1] != den[SUM_W-1])
            in_unit = 1'b0;
        else
            in_unit = (nm <= dm);
    endfunction

    logic v1_reg, v2_reg, v3_reg;
    logic j1_reg, j2_reg, j3_reg;
    logic signed [DIFF_W-1:0] dxa_reg, dya_reg, dxb_reg, dyb_reg, dx13_reg, dy13_reg;
    logic signed [PROD_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [SUM_W-1:0]  den_reg, ta_reg, ub_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (enable)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Differences, products, cross sums
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            j1_reg   <= (x2 == x3) && (y2 == y3);
            dxa_reg  <= DIFF_W'(x1) - DIFF_W'(x2);
            dya_reg  <= DIFF_W'(y1) - DIFF_W'(y2);
            dxb_reg  <= DIFF_W'(x3) - DIFF_W'(x4);
            dyb_reg  <= DIFF_W'(y3) - DIFF_W'(y4);
            dx13_reg <= DIFF_W'(x1) - DIFF_W'(x3);
            dy13_reg <= DIFF_W'(y1) - DIFF_W'(y3);

            j2_reg <= j1_reg;
            p0_reg <= PROD_W'(dxa_reg) * PROD_W'(dyb_reg);
            p1_reg <= PROD_W'(dya_reg) * PROD_W'(dxb_reg);
            p2_reg <= PROD_W'(dx13_reg) * PROD_W'(dyb_reg);
            p3_reg <= PROD_W'(dy13_reg) * PROD_W'(dxb_reg);
            p4_reg <= PROD_W'(dya_reg) * PROD_W'(dx13_reg);
            p5_reg <= PROD_W'(dxa_reg) * PROD_W'(dy13_reg);

            j3_reg  <= j2_reg;
            den_reg <= SUM_W'(p0_reg) - SUM_W'(p1_reg);
            ta_reg  <= SUM_W'(p2_reg) - SUM_W'(p3_reg);
            ub_reg  <= SUM_W'(p4_reg) - SUM_W'(p5_reg);
        end
    end

    // Hit qualification and divider operands
    logic [SUM_W-1:0] dmag;
    logic [SUM_W-1:0] nmag;

    always_comb
    begin
        dmag = den_reg[SUM_W-1] ? SUM_W'(-den_reg) : SUM_W'(den_reg);
        nmag = ub_reg[SUM_W-1] ? SUM_W'(-ub_reg) : SUM_W'(ub_reg);
        out_beat.ok = !j3_reg && (dmag >= SUM_W'(thresh)) && (dmag != '0)
                      && in_unit(ta_reg, den_reg) && in_unit(ub_reg, den_reg);
        out_beat.eq   = (nmag == dmag);
        out_beat.dmag = dmag;
        out_beat.rem  = nmag;
        out_beat.quo  = '0;
    end

    assign out_valid = v3_reg;

endmodule

// ----- src/sgi_div_cell.sv -----
module sgi_div_cell
    import sgi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     enable,
    input  logic     in_valid,
    input  sgi_div_t in_beat,
    output logic     out_valid,
    output sgi_div_t out_beat
);

    logic     valid_reg;
    sgi_div_t beat_reg;
    sgi_div_t beat_next;
    logic [SUM_W:0] rem2;
    logic           ge;

    // One restoring step: shift, trial subtract, take a quotient bit
    always_comb
    begin
        rem2      = {in_beat.rem, 1'b0};
        ge        = rem2 >= {1'b0, in_beat.dmag};
        beat_next = in_beat;
        beat_next.rem = ge ? SUM_W'(rem2 - {1'b0, in_beat.dmag}) : rem2[SUM_W-1:0];
        beat_next.quo = {in_beat.quo[CUT_FRACTION_BITS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (enable)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (enable)
            beat_reg <= beat_next;
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// ----- src/segment_intersection_unit.sv -----
// Segment pair intersection: one segment pair per clock in, one hit/cut beat per
// clock out. Differences, products and cross sums are registered in turn, then
// come a chain of 16 divider cells with one cut bit per cell and one output
// register. The whole pipeline advances together and holds while a result
// waits at the output, so throughput is one beat per cycle whenever the sink
// takes results. parallel_threshold sits at byte address 0 of the APB port.
module segment_intersection_unit
    import sgi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    sgi_seg_if.sink           in_seg,
    sgi_res_if.source         out_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [THRESH_W-1:0] thresh_reg;
    logic                out_valid_reg;
    logic                hit_reg;
    logic [CUT_W-1:0]    cut_reg;
    logic                enable;
    logic                cfg_wr;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[3] == REG_THRESH);
    assign prdata = (paddr[3] == REG_THRESH) ? DATA_W'(thresh_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= THRESH_RESET;
        else if (cfg_wr)
            thresh_reg <= pwdata[THRESH_W-1:0];
    end

    // Global advance
    assign enable       = !out_valid_reg || out_res.ready;
    assign in_seg.ready = enable;

    logic     chain_valid [0:CUT_FRACTION_BITS];
    sgi_div_t chain_beat  [0:CUT_FRACTION_BITS];

    sgi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (enable),
        .in_valid  (in_seg.valid),
        .x1        (in_seg.a_start_x),
        .y1        (in_seg.a_start_y),
        .x2        (in_seg.a_end_x),
        .y2        (in_seg.a_end_y),
        .x3        (in_seg.b_start_x),
        .y3        (in_seg.b_start_y),
        .x4        (in_seg.b_end_x),
        .y4        (in_seg.b_end_y),
        .thresh    (thresh_reg),
        .out_valid (chain_valid[0]),
        .out_beat  (chain_beat[0])
    );

    // Divider chain, one cut bit per cell
    for (genvar g = 0; g < CUT_FRACTION_BITS; g++)
    begin : g_cell
        sgi_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .enable    (enable),
            .in_valid  (chain_valid[g]),
            .in_beat   (chain_beat[g]),
            .out_valid (chain_valid[g+1]),
            .out_beat  (chain_beat[g+1])
        );
    end

    // Output register
    sgi_div_t last;
    assign last = chain_beat[CUT_FRACTION_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (enable)
            out_valid_reg <= chain_valid[CUT_FRACTION_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            hit_reg <= last.ok;
            if (!last.ok)
                cut_reg <= '0;
            else if (last.eq)
                cut_reg <= CUT_W'(1) << CUT_FRACTION_BITS;
            else
                cut_reg <= {1'b0, last.quo};
        end
    end

    assign out_res.valid = out_valid_reg;
    assign out_res.hit   = hit_reg;
    assign out_res.cut   = cut_reg;

    // Checks
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !hit_reg |-> cut_reg == '0)
        else $error("miss with nonzero cut");

    a_cut_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && cut_reg[CUT_FRACTION_BITS] |->
            cut_reg[CUT_FRACTION_BITS-1:0] == '0)
        else $error("cut above 1.0");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> thresh_reg == $past(pwdata[THRESH_W-1:0]))
        else $error("threshold write lost");

endmodule

// ----- test/tb_segment_intersection_unit.sv -----
`timescale 1ns / 100ps

module tb_segment_intersection_unit;
    import sgi_pkg::*;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t a_start_x;
        coord_t a_start_y;
        coord_t a_end_x;
        coord_t a_end_y;
        coord_t b_start_x;
        coord_t b_start_y;
        coord_t b_end_x;
        coord_t b_end_y;
    } seg_pair_t;

    typedef struct packed {
        logic             hit;
        logic [CUT_W-1:0] cut;
    } crossing_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PIPE_LATENCY = 20;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    sgi_seg_if seg_ch();
    sgi_res_if res_ch();

    segment_intersection_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_seg  (seg_ch.sink),
        .out_res (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state
    logic [THRESH_W-1:0] thresh_model;
    seg_pair_t pending_pairs[$];
    crossing_t expected_crossings[$];
    int mismatch_count;
    int cycle_count;
    int send_gap;
    int recv_gap;
    bit hold_sender;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Predict one result for a segment pair
    function automatic crossing_t predict_crossing(seg_pair_t p);
        crossing_t res;
        longint x1, y1, x2, y2, x3, y3, x4, y4;
        longint dxa, dya, dxb, dyb, dx13, dy13, den, ta, ub, dmag, n, r, q;
        bit in_range;
        res = '0;
        x1 = p.a_start_x; y1 = p.a_start_y;
        x2 = p.a_end_x;   y2 = p.a_end_y;
        x3 = p.b_start_x; y3 = p.b_start_y;
        x4 = p.b_end_x;   y4 = p.b_end_y;
        // shared joint
        if (x2 == x3 && y2 == y3)
            return res;
        dxa = x1 - x2; dya = y1 - y2;
        dxb = x3 - x4; dyb = y3 - y4;
        dx13 = x1 - x3; dy13 = y1 - y3;
        den = dxa * dyb - dya * dxb;
        dmag = (den < 0) ? -den : den;
        if (dmag < longint'(thresh_model) || dmag == 0)
            return res;
        ta = dx13 * dyb - dy13 * dxb;
        in_range = (ta == 0) || (((ta < 0) == (den < 0)) && ((ta < 0 ? -ta : ta) <= dmag));
        if (!in_range)
            return res;
        ub = dya * dx13 - dxa * dy13;
        in_range = (ub == 0) || (((ub < 0) == (den < 0)) && ((ub < 0 ? -ub : ub) <= dmag));
        if (!in_range)
            return res;
        n = (ub < 0) ? -ub : ub;
        if (n == dmag)
            q = longint'(1) << CUT_FRACTION_BITS;
        else
            q = (n << CUT_FRACTION_BITS) / dmag;
        res.hit = 1'b1;
        res.cut = q[CUT_W-1:0];
        return res;
    endfunction

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_ch.valid <= 1'b0;
            send_gap <= 0;
        end
        else if (seg_ch.valid && !seg_ch.ready)
        begin
            // hold current beat
        end
        else if (send_gap > 0)
        begin
            seg_ch.valid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (pending_pairs.size() > 0 && !hold_sender)
        begin
            seg_pair_t p;
            p = pending_pairs.pop_front();
            expected_crossings.push_back(predict_crossing(p));
            seg_ch.valid <= 1'b1;
            seg_ch.a_start_x <= p.a_start_x;
            seg_ch.a_start_y <= p.a_start_y;
            seg_ch.a_end_x <= p.a_end_x;
            seg_ch.a_end_y <= p.a_end_y;
            seg_ch.b_start_x <= p.b_start_x;
            seg_ch.b_start_y <= p.b_start_y;
            seg_ch.b_end_x <= p.b_end_x;
            seg_ch.b_end_y <= p.b_end_y;
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16)
                        * ($urandom_range(0, 1));
        end
        else
            seg_ch.valid <= 1'b0;
    end

    // Monitor and result sink stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                crossing_t want;
                if (expected_crossings.size() == 0)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected beat: hit=%0d cut=%0d", res_ch.hit, res_ch.cut);
                end
                else
                begin
                    want = expected_crossings.pop_front();
                    if (want.hit !== res_ch.hit || want.cut !== res_ch.cut)
                    begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                            $display("mismatch: expected hit=%0d cut=%0d, got hit=%0d cut=%0d",
                                     want.hit, want.cut, res_ch.hit, res_ch.cut);
                    end
                end
            end
            if (recv_gap > 0)
            begin
                res_ch.ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                if (res_ch.valid && res_ch.ready)
                    recv_gap <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
            end
        end
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("segment_intersection_unit regression: fail");
            $finish;
        end
    end

    task automatic write_threshold(input logic [THRESH_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(int'(REG_THRESH) * 8);
        pwdata <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        thresh_model = value;
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() > 0 || seg_ch.valid || expected_crossings.size() > 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    function automatic coord_t rand_coord(int span);
        if (span == 0)
            return coord_t'($urandom);
        return coord_t'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic seg_pair_t rand_pair();
        seg_pair_t p;
        int span;
        int mode;
        mode = $urandom_range(0, 9);
        span = (mode < 3) ? 0 : ((mode < 7) ? 1000 : 40);
        p.a_start_x = rand_coord(span);
        p.a_start_y = rand_coord(span);
        p.a_end_x = rand_coord(span);
        p.a_end_y = rand_coord(span);
        p.b_start_x = rand_coord(span);
        p.b_start_y = rand_coord(span);
        p.b_end_x = rand_coord(span);
        p.b_end_y = rand_coord(span);
        // occasionally shared joint or parallel pair
        if (mode == 9)
        begin
            p.b_start_x = p.a_end_x;
            p.b_start_y = p.a_end_y;
        end
        else if (mode == 8)
        begin
            p.b_end_x = p.b_start_x + (p.a_end_x - p.a_start_x);
            p.b_end_y = p.b_start_y + (p.a_end_y - p.a_start_y);
        end
        return p;
    endfunction

    function automatic seg_pair_t mk(int ax, int ay, int bx, int by,
                                     int cx, int cy, int dx, int dy);
        seg_pair_t p;
        p.a_start_x = coord_t'(ax); p.a_start_y = coord_t'(ay);
        p.a_end_x = coord_t'(bx);   p.a_end_y = coord_t'(by);
        p.b_start_x = coord_t'(cx); p.b_start_y = coord_t'(cy);
        p.b_end_x = coord_t'(dx);   p.b_end_y = coord_t'(dy);
        return p;
    endfunction

    task automatic push_random(int count);
        repeat (count) pending_pairs.push_back(rand_pair());
    endtask

    // Stimulus
    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        seg_ch.valid = 1'b0;
        seg_ch.a_start_x = '0; seg_ch.a_start_y = '0;
        seg_ch.a_end_x = '0;   seg_ch.a_end_y = '0;
        seg_ch.b_start_x = '0; seg_ch.b_start_y = '0;
        seg_ch.b_end_x = '0;   seg_ch.b_end_y = '0;
        res_ch.ready = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        hold_sender = 1'b0;
        thresh_model = THRESH_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed cases at reset threshold
        pending_pairs.push_back(mk(-100, 0, 100, 0, 0, -100, 0, 100));       // crossing mid
        pending_pairs.push_back(mk(0, 0, 100, 100, 100, 100, 200, 0));       // shared joint
        pending_pairs.push_back(mk(0, 0, 100, 0, 0, 10, 100, 10));           // parallel
        pending_pairs.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));                 // degenerate
        pending_pairs.push_back(mk(-100, 0, 100, 0, 0, 0, 0, 100));          // u = 0
        pending_pairs.push_back(mk(-100, 0, 100, 0, 0, -100, 0, 0));         // u = 1
        pending_pairs.push_back(mk(-100, 0, 100, 0, 0, 10, 0, 100));         // u out of range
        pending_pairs.push_back(mk(0, 0, 50, 0, 100, -10, 100, 10));         // t out of range
        pending_pairs.push_back(mk(-32768, -32768, 32767, 32767,
                                   -32768, 32767, 32767, -32768));           // extremes
        pending_pairs.push_back(mk(32767, -32768, -32768, 32767,
                                   32767, 32767, -32768, -32768));
        pending_pairs.push_back(mk(-32768, 0, 32767, 0, 0, 32767, 1, -32768));
        pending_pairs.push_back(mk(-1, -1, -1, -1, -1, -1, -1, -1));
        pending_pairs.push_back(mk(0, 0, 3, 0, 1, -1, 1, 2));               // cut a third
        push_random(40);
        wait_drained();

        // zero threshold: zero denominator still counts as parallel
        write_threshold('0);
        pending_pairs.push_back(mk(0, 0, 100, 0, 0, 10, 100, 10));
        pending_pairs.push_back(mk(0, 0, 100, 0, 50, 0, 60, 0));
        push_random(90);
        // sender pauses mid-stream until every result is back
        while (pending_pairs.size() > 45)
            @(posedge clk);
        hold_sender = 1'b1;
        while (seg_ch.valid || expected_crossings.size() > 0)
            @(posedge clk);
        hold_sender = 1'b0;
        wait_drained();
        push_random(60);
        wait_drained();

        // maximal threshold: nothing hits
        write_threshold({THRESH_W{1'b1}});
        push_random(60);
        wait_drained();

        // mid thresholds
        write_threshold(THRESH_W'(20000));
        pending_pairs.push_back(mk(-100, 0, 100, 0, 0, -50, 0, 50));        // |d| exactly 20000
        pending_pairs.push_back(mk(-100, 0, 100, 0, 0, -49, 0, 50));
        push_random(80);
        wait_drained();

        write_threshold(THRESH_W'($urandom_range(1, 1 << 20)));
        push_random(80);
        wait_drained();

        if (mismatch_count == 0)
            $display("segment_intersection_unit regression: pass");
        else
            $display("segment_intersection_unit regression: fail");
        $finish;
    end

endmodule

// ----- sim.f -----
src/sgi_pkg.sv
src/sgi_channels.sv
src/sgi_front.sv
src/sgi_div_cell.sv
src/segment_intersection_unit.sv
test/tb_segment_intersection_unit.sv
